FILE: src/mer_pkg.sv
// Shared types, constants and control codes for the midpoint ellipse rasterizer.
// No dependencies; every other file of the block refers to this package by scoped names.
package mer_pkg;

  // Coordinate width of the center and radius fields.
  localparam int COORD_BITS = 10;
  // Step counters need one bit more than a coordinate.
  localparam int STEP_BITS = COORD_BITS + 1;
  // Decision values are kept as 48-bit two's complement, four times the real value.
  localparam int DEC_BITS = 48;
  localparam int PIX_BITS = 12;
  // Signed coordinate operand of the shared multiplier: holds 2x+1 and y-1.
  localparam int MUL_B_BITS = COORD_BITS + 3;
  localparam int MUL_P_BITS = DEC_BITS + MUL_B_BITS;
  localparam int SQ_BITS = 2 * COORD_BITS;
  // Width of the exact products ry^2*x and rx^2*y used by the region tests.
  localparam int CMP_BITS = 3 * COORD_BITS + 1;
  localparam int PIX_CALC_BITS = (COORD_BITS + 2 > PIX_BITS) ? COORD_BITS + 2 : PIX_BITS;

  localparam logic OP_START = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] radius_x;
    logic [COORD_BITS-1:0] radius_y;
  } req_t;

  typedef struct packed {
    logic signed [PIX_BITS-1:0] pixel_x;
    logic signed [PIX_BITS-1:0] pixel_y;
    logic                       pixel_valid;
    logic                       last_of_step;
    logic                       finished;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT_RX2,
    ST_INIT_RY2,
    ST_INIT_PRD,
    ST_INIT_DEC,
    ST_EMIT_TOP,
    ST_TEST_LHS,
    ST_TEST_RHS,
    ST_TEST,
    ST_R1_X,
    ST_R1_DEC,
    ST_R1_Y,
    ST_R1_DECY,
    ST_R2_T,
    ST_R2_TT,
    ST_R2_YM,
    ST_R2_YMYM,
    ST_R2_RR,
    ST_R2_RRR,
    ST_R2_DEC,
    ST_R2_Y,
    ST_R2_DECY,
    ST_R2_X,
    ST_R2_DECX,
    ST_EMIT0,
    ST_EMIT1,
    ST_EMIT2,
    ST_EMIT3,
    ST_EMIT_FIN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_REGION1,
    PH_REGION2,
    PH_DONE
  } phase_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_RX,
    OP_SQ_RY,
    OP_RX2_RY,
    OP_INIT_DEC,
    OP_MUL_RY2_X,
    OP_MUL_RX2_Y,
    OP_INC_X_MUL,
    OP_R1_DEC,
    OP_DEC_Y_MUL,
    OP_SUB8,
    OP_MUL_RY2_T,
    OP_MUL_PROD_T,
    OP_MUL_RX2_YM,
    OP_MUL_PROD_YM,
    OP_MUL_RX2_RY,
    OP_MUL_PROD_RY,
    OP_R2_INIT,
    OP_R2_DEC,
    OP_ADD8
  } dp_op_t;

  typedef enum logic [2:0] {
    SEL_TOP,
    SEL_PP,
    SEL_MP,
    SEL_PM,
    SEL_MM,
    SEL_FIN
  } pix_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     load_out;
    pix_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic rad_zero;
    logic le;
    logic ge;
    logic y_zero;
    logic dec_neg;
    logic dec_pos;
  } dp_status_t;

endpackage

FILE: src/mer_datapath.sv
// Datapath of the ellipse rasterizer: held ellipse, step counters, decision value,
// one shared registered multiplier and the result register. Uses mer_pkg.
module mer_datapath (
  input  logic                clk,
  input  mer_pkg::req_t       req,
  input  mer_pkg::dp_cmd_t    cmd,
  output mer_pkg::dp_status_t status,
  output mer_pkg::rsp_t       rsp
);

  localparam int CB = mer_pkg::COORD_BITS;
  localparam int SB = mer_pkg::STEP_BITS;
  localparam int DW = mer_pkg::DEC_BITS;
  localparam int BW = mer_pkg::MUL_B_BITS;
  localparam int PW = mer_pkg::MUL_P_BITS;
  localparam int QW = mer_pkg::SQ_BITS;
  localparam int CW = mer_pkg::CMP_BITS;
  localparam int EW = mer_pkg::PIX_CALC_BITS;
  localparam int XW = mer_pkg::PIX_BITS;

  logic [CB-1:0] held_center_x;
  logic [CB-1:0] held_center_y;
  logic [CB-1:0] held_radius_x;
  logic [CB-1:0] held_radius_y;
  logic [QW-1:0] rx2;
  logic [QW-1:0] ry2;
  logic [SB-1:0] step_x;
  logic [SB-1:0] step_y;
  logic [DW-1:0] decision;
  logic [DW-1:0] acc;
  logic [CW-1:0] lhs;
  logic signed [PW-1:0] prod;

  logic                 mul_en;
  logic signed [DW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic [DW-1:0]        p48;
  logic [DW-1:0]        rx2_d;
  logic [DW-1:0]        ry2_d;
  logic [BW-1:0]        x_inc;
  logic [BW-1:0]        y_dec;
  logic [BW-1:0]        t_val;

  logic [EW-1:0] cx_e;
  logic [EW-1:0] cy_e;
  logic [EW-1:0] x_e;
  logic [EW-1:0] y_e;
  logic [EW-1:0] ry_e;
  logic [EW-1:0] sum_xp;
  logic [EW-1:0] sum_xm;
  logic [EW-1:0] sum_yp;
  logic [EW-1:0] sum_ym;
  logic [EW-1:0] sum_top;
  mer_pkg::rsp_t rsp_next;

  assign p48   = prod[DW-1:0];
  assign rx2_d = DW'(rx2);
  assign ry2_d = DW'(ry2);
  assign x_inc = BW'(step_x) + BW'(1'b1);
  assign y_dec = BW'(step_y) - BW'(1'b1);
  assign t_val = BW'({step_x, 1'b1});

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      mer_pkg::OP_SQ_RX: begin
        mul_a = DW'(held_radius_x);
        mul_b = BW'(held_radius_x);
      end
      mer_pkg::OP_SQ_RY: begin
        mul_a = DW'(held_radius_y);
        mul_b = BW'(held_radius_y);
      end
      mer_pkg::OP_RX2_RY, mer_pkg::OP_MUL_RX2_RY: begin
        mul_a = rx2_d;
        mul_b = BW'(held_radius_y);
      end
      mer_pkg::OP_MUL_RY2_X: begin
        mul_a = ry2_d;
        mul_b = BW'(step_x);
      end
      mer_pkg::OP_MUL_RX2_Y: begin
        mul_a = rx2_d;
        mul_b = BW'(step_y);
      end
      mer_pkg::OP_INC_X_MUL: begin
        mul_a = ry2_d;
        mul_b = x_inc;
      end
      mer_pkg::OP_DEC_Y_MUL, mer_pkg::OP_MUL_RX2_YM: begin
        mul_a = rx2_d;
        mul_b = y_dec;
      end
      mer_pkg::OP_MUL_RY2_T: begin
        mul_a = ry2_d;
        mul_b = t_val;
      end
      mer_pkg::OP_MUL_PROD_T: begin
        mul_a = p48;
        mul_b = t_val;
      end
      mer_pkg::OP_MUL_PROD_YM: begin
        mul_a = p48;
        mul_b = y_dec;
      end
      mer_pkg::OP_MUL_PROD_RY: begin
        mul_a = p48;
        mul_b = BW'(held_radius_y);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Register updates; all decision arithmetic wraps at 48 bits.
  always_ff @(posedge clk) begin
    case (cmd.op)
      mer_pkg::OP_LOAD: begin
        held_center_x <= req.center_x;
        held_center_y <= req.center_y;
        held_radius_x <= req.radius_x;
        held_radius_y <= req.radius_y;
        step_x        <= '0;
        step_y        <= SB'(req.radius_y);
      end
      mer_pkg::OP_SQ_RY:    rx2 <= prod[QW-1:0];
      mer_pkg::OP_RX2_RY:   ry2 <= prod[QW-1:0];
      mer_pkg::OP_INIT_DEC: decision <= (ry2_d << 2) + rx2_d - (p48 << 2);
      mer_pkg::OP_MUL_RX2_Y: lhs <= prod[CW-1:0];
      mer_pkg::OP_INC_X_MUL: step_x <= x_inc[SB-1:0];
      mer_pkg::OP_R1_DEC:   decision <= decision + (p48 << 3) + (ry2_d << 2);
      mer_pkg::OP_DEC_Y_MUL: step_y <= y_dec[SB-1:0];
      mer_pkg::OP_SUB8:     decision <= decision - (p48 << 3);
      mer_pkg::OP_MUL_RX2_YM: acc <= p48;
      mer_pkg::OP_MUL_RX2_RY: acc <= acc + (p48 << 2);
      mer_pkg::OP_R2_INIT:  decision <= acc - (p48 << 2);
      mer_pkg::OP_R2_DEC:   decision <= decision + (rx2_d << 2) - (p48 << 3);
      mer_pkg::OP_ADD8:     decision <= decision + (p48 << 3);
      default: ;
    endcase
  end

  assign status.rad_zero = (held_radius_x == '0) || (held_radius_y == '0);
  assign status.le       = lhs <= prod[CW-1:0];
  assign status.ge       = lhs >= prod[CW-1:0];
  assign status.y_zero   = step_y == '0;
  assign status.dec_neg  = decision[DW-1];
  assign status.dec_pos  = !decision[DW-1] && (decision != '0);

  // Mirrored pixel coordinates, wrapped to the pixel width.
  assign cx_e    = EW'(held_center_x);
  assign cy_e    = EW'(held_center_y);
  assign x_e     = EW'(step_x);
  assign y_e     = EW'(step_y);
  assign ry_e    = EW'(held_radius_y);
  assign sum_xp  = cx_e + x_e;
  assign sum_xm  = cx_e - x_e;
  assign sum_yp  = cy_e + y_e;
  assign sum_ym  = cy_e - y_e;
  assign sum_top = cy_e + ry_e;

  always_comb begin
    rsp_next.pixel_x      = '0;
    rsp_next.pixel_y      = '0;
    rsp_next.pixel_valid  = 1'b1;
    rsp_next.last_of_step = 1'b0;
    rsp_next.finished     = 1'b0;
    case (cmd.sel)
      mer_pkg::SEL_TOP: begin
        rsp_next.pixel_x      = cx_e[XW-1:0];
        rsp_next.pixel_y      = sum_top[XW-1:0];
        rsp_next.last_of_step = 1'b1;
      end
      mer_pkg::SEL_PP: begin
        rsp_next.pixel_x = sum_xp[XW-1:0];
        rsp_next.pixel_y = sum_yp[XW-1:0];
      end
      mer_pkg::SEL_MP: begin
        rsp_next.pixel_x = sum_xm[XW-1:0];
        rsp_next.pixel_y = sum_yp[XW-1:0];
      end
      mer_pkg::SEL_PM: begin
        rsp_next.pixel_x = sum_xp[XW-1:0];
        rsp_next.pixel_y = sum_ym[XW-1:0];
      end
      mer_pkg::SEL_MM: begin
        rsp_next.pixel_x      = sum_xm[XW-1:0];
        rsp_next.pixel_y      = sum_ym[XW-1:0];
        rsp_next.last_of_step = 1'b1;
      end
      default: begin
        rsp_next.pixel_valid  = 1'b0;
        rsp_next.last_of_step = 1'b1;
        rsp_next.finished     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: src/mer_ctrl.sv
// Controller of the ellipse rasterizer: sequences the datapath one operation per cycle
// unless a result stall holds it, and owns the request and result handshakes. Uses mer_pkg.
module mer_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  input  logic                req_op,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  mer_pkg::dp_status_t status,
  output mer_pkg::dp_cmd_t    cmd
);

  mer_pkg::ctrl_state_t state;
  mer_pkg::ctrl_state_t state_next;
  mer_pkg::phase_t      phase;
  mer_pkg::phase_t      phase_next;
  logic                 rsp_valid_next;
  logic                 can_load;

  // The result register may take a new result when it is empty or being drained.
  assign can_load       = !rsp_valid || !rsp_stall;
  assign req_stall      = state != mer_pkg::ST_IDLE;
  assign rsp_valid_next = cmd.load_out || (rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mer_pkg::ST_IDLE;
      phase     <= mer_pkg::PH_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      mer_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (req_op == mer_pkg::OP_START) begin
            state_next = mer_pkg::ST_INIT_RX2;
          end else if (phase == mer_pkg::PH_REGION1 || phase == mer_pkg::PH_REGION2) begin
            state_next = mer_pkg::ST_TEST_LHS;
          end else begin
            state_next = mer_pkg::ST_EMIT_FIN;
          end
        end
      end
      mer_pkg::ST_INIT_RX2: state_next = mer_pkg::ST_INIT_RY2;
      mer_pkg::ST_INIT_RY2: state_next = mer_pkg::ST_INIT_PRD;
      mer_pkg::ST_INIT_PRD: state_next = mer_pkg::ST_INIT_DEC;
      mer_pkg::ST_INIT_DEC: begin
        state_next = mer_pkg::ST_EMIT_TOP;
        phase_next = status.rad_zero ? mer_pkg::PH_DONE : mer_pkg::PH_REGION1;
      end
      mer_pkg::ST_EMIT_TOP: begin
        if (can_load) begin
          state_next = mer_pkg::ST_IDLE;
        end
      end
      mer_pkg::ST_TEST_LHS: state_next = mer_pkg::ST_TEST_RHS;
      mer_pkg::ST_TEST_RHS: state_next = mer_pkg::ST_TEST;
      mer_pkg::ST_TEST: begin
        if (phase == mer_pkg::PH_REGION1) begin
          state_next = status.le ? mer_pkg::ST_R1_X : mer_pkg::ST_R2_T;
        end else if (!status.y_zero && status.ge) begin
          state_next = mer_pkg::ST_R2_Y;
        end else begin
          state_next = mer_pkg::ST_EMIT_FIN;
        end
      end
      mer_pkg::ST_R1_X: state_next = mer_pkg::ST_R1_DEC;
      // The branch looks at the decision value from before this cycle's update.
      mer_pkg::ST_R1_DEC: state_next = status.dec_neg ? mer_pkg::ST_EMIT0 : mer_pkg::ST_R1_Y;
      mer_pkg::ST_R1_Y:    state_next = mer_pkg::ST_R1_DECY;
      mer_pkg::ST_R1_DECY: state_next = mer_pkg::ST_EMIT0;
      mer_pkg::ST_R2_T:    state_next = mer_pkg::ST_R2_TT;
      mer_pkg::ST_R2_TT:   state_next = mer_pkg::ST_R2_YM;
      mer_pkg::ST_R2_YM:   state_next = mer_pkg::ST_R2_YMYM;
      mer_pkg::ST_R2_YMYM: state_next = mer_pkg::ST_R2_RR;
      mer_pkg::ST_R2_RR:   state_next = mer_pkg::ST_R2_RRR;
      mer_pkg::ST_R2_RRR:  state_next = mer_pkg::ST_R2_DEC;
      // After the region-two setup the same advance runs the region-two test.
      mer_pkg::ST_R2_DEC: begin
        state_next = mer_pkg::ST_TEST_LHS;
        phase_next = mer_pkg::PH_REGION2;
      end
      mer_pkg::ST_R2_Y: state_next = mer_pkg::ST_R2_DECY;
      mer_pkg::ST_R2_DECY: state_next = status.dec_pos ? mer_pkg::ST_EMIT0 : mer_pkg::ST_R2_X;
      mer_pkg::ST_R2_X:    state_next = mer_pkg::ST_R2_DECX;
      mer_pkg::ST_R2_DECX: state_next = mer_pkg::ST_EMIT0;
      mer_pkg::ST_EMIT0: begin
        if (can_load) begin
          state_next = mer_pkg::ST_EMIT1;
        end
      end
      mer_pkg::ST_EMIT1: begin
        if (can_load) begin
          state_next = mer_pkg::ST_EMIT2;
        end
      end
      mer_pkg::ST_EMIT2: begin
        if (can_load) begin
          state_next = mer_pkg::ST_EMIT3;
        end
      end
      mer_pkg::ST_EMIT3: begin
        if (can_load) begin
          state_next = mer_pkg::ST_IDLE;
        end
      end
      mer_pkg::ST_EMIT_FIN: begin
        if (can_load) begin
          state_next = mer_pkg::ST_IDLE;
          phase_next = mer_pkg::PH_DONE;
        end
      end
      default: state_next = mer_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = mer_pkg::OP_NONE;
    cmd.load_out = 1'b0;
    cmd.sel      = mer_pkg::SEL_TOP;
    case (state)
      mer_pkg::ST_IDLE: begin
        if (req_valid && req_op == mer_pkg::OP_START) begin
          cmd.op = mer_pkg::OP_LOAD;
        end
      end
      mer_pkg::ST_INIT_RX2: cmd.op = mer_pkg::OP_SQ_RX;
      mer_pkg::ST_INIT_RY2: cmd.op = mer_pkg::OP_SQ_RY;
      mer_pkg::ST_INIT_PRD: cmd.op = mer_pkg::OP_RX2_RY;
      mer_pkg::ST_INIT_DEC: cmd.op = mer_pkg::OP_INIT_DEC;
      mer_pkg::ST_EMIT_TOP: begin
        cmd.load_out = can_load;
        cmd.sel      = mer_pkg::SEL_TOP;
      end
      mer_pkg::ST_TEST_LHS: cmd.op = mer_pkg::OP_MUL_RY2_X;
      mer_pkg::ST_TEST_RHS: cmd.op = mer_pkg::OP_MUL_RX2_Y;
      mer_pkg::ST_R1_X:     cmd.op = mer_pkg::OP_INC_X_MUL;
      mer_pkg::ST_R1_DEC:   cmd.op = mer_pkg::OP_R1_DEC;
      mer_pkg::ST_R1_Y:     cmd.op = mer_pkg::OP_DEC_Y_MUL;
      mer_pkg::ST_R1_DECY:  cmd.op = mer_pkg::OP_SUB8;
      mer_pkg::ST_R2_T:     cmd.op = mer_pkg::OP_MUL_RY2_T;
      mer_pkg::ST_R2_TT:    cmd.op = mer_pkg::OP_MUL_PROD_T;
      mer_pkg::ST_R2_YM:    cmd.op = mer_pkg::OP_MUL_RX2_YM;
      mer_pkg::ST_R2_YMYM:  cmd.op = mer_pkg::OP_MUL_PROD_YM;
      mer_pkg::ST_R2_RR:    cmd.op = mer_pkg::OP_MUL_RX2_RY;
      mer_pkg::ST_R2_RRR:   cmd.op = mer_pkg::OP_MUL_PROD_RY;
      mer_pkg::ST_R2_DEC:   cmd.op = mer_pkg::OP_R2_INIT;
      mer_pkg::ST_R2_Y:     cmd.op = mer_pkg::OP_DEC_Y_MUL;
      mer_pkg::ST_R2_DECY:  cmd.op = mer_pkg::OP_R2_DEC;
      mer_pkg::ST_R2_X:     cmd.op = mer_pkg::OP_INC_X_MUL;
      mer_pkg::ST_R2_DECX:  cmd.op = mer_pkg::OP_ADD8;
      mer_pkg::ST_EMIT0: begin
        cmd.load_out = can_load;
        cmd.sel      = mer_pkg::SEL_PP;
      end
      mer_pkg::ST_EMIT1: begin
        cmd.load_out = can_load;
        cmd.sel      = mer_pkg::SEL_MP;
      end
      mer_pkg::ST_EMIT2: begin
        cmd.load_out = can_load;
        cmd.sel      = mer_pkg::SEL_PM;
      end
      mer_pkg::ST_EMIT3: begin
        cmd.load_out = can_load;
        cmd.sel      = mer_pkg::SEL_MM;
      end
      mer_pkg::ST_EMIT_FIN: begin
        cmd.load_out = can_load;
        cmd.sel      = mer_pkg::SEL_FIN;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_setup_from_region1: assert property (@(posedge clk) disable iff (rst)
    (state == mer_pkg::ST_R2_T) |-> (phase == mer_pkg::PH_REGION1))
    else $error("region-two setup entered outside region one");
  a_step_in_region: assert property (@(posedge clk) disable iff (rst)
    (state == mer_pkg::ST_EMIT0) |->
    (phase == mer_pkg::PH_REGION1 || phase == mer_pkg::PH_REGION2))
    else $error("pixel step emitted outside an active region");
  a_fin_sets_done: assert property (@(posedge clk) disable iff (rst)
    (state == mer_pkg::ST_EMIT_FIN && cmd.load_out) |=> (phase == mer_pkg::PH_DONE))
    else $error("finished result did not mark the ellipse done");
  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    (phase == mer_pkg::PH_DONE && state != mer_pkg::ST_INIT_DEC) |=>
    (phase == mer_pkg::PH_DONE))
    else $error("done ellipse resumed without a start request");
  a_y_zero_ends: assert property (@(posedge clk) disable iff (rst)
    (state == mer_pkg::ST_TEST && phase == mer_pkg::PH_REGION2 && status.y_zero) |=>
    (state == mer_pkg::ST_EMIT_FIN))
    else $error("region two stepped past y equal to zero");
`endif

endmodule

FILE: src/midpoint_ellipse_rasterizer_top.sv
// Top level of the midpoint ellipse rasterizer: joins the controller and the datapath.
// Depends on mer_pkg, mer_ctrl and mer_datapath.

// A start request latches center and radii and, after the init states ST_INIT_RX2 to
// ST_INIT_DEC, offers the top point as one result. An advance request runs one
// midpoint step and gives the four mirrored pixels, or a single finished result once
// the ellipse is complete or none was started. The block works on one request at a
// time; every product of the decision arithmetic comes from one shared, registered
// multiplier, one product per cycle. An ordinary step runs the region test, the
// decision update and the four result states; the advance that crosses into region
// two also runs the region-two setup for the new decision value, and a finished result
// follows directly or after a region test that fails. The block returns to the idle
// state before the next request is taken. Result states wait while the result side
// stalls. req_stall is low only while the block waits for a request.
module midpoint_ellipse_rasterizer_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mer_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mer_pkg::rsp_t rsp
);

  mer_pkg::dp_cmd_t    cmd;
  mer_pkg::dp_status_t status;

  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.op),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mer_datapath u_datapath (
    .clk    (clk),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

endmodule
